/* sv/svam_pkg.sv */
// shared types and constants for the sparse merge-add block
// used by svam_ctrl, svam_dp and sparse_vector_axpy_mod_p; no dependencies
package svam_pkg;

  localparam int VALUE_BITS_DEF = 16;
  localparam int INDEX_BITS_DEF = 20;
  localparam int CFG_IDX_BITS   = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_MODULUS = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SCALE   = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic load_a;
    logic load_prod;
    logic step;
    logic save_a;
    logic calc_val;
    logic finish;
  } svam_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic none_present;
    logic take_a;
    logic take_b;
    logic rem_last;
    logic out_free;
  } svam_stat_t;

endpackage

/* sv/sparse_vector_axpy_mod_p.sv */
// one word of v1 + f*v2 over GF(p): with no head the word goes straight to the
// result; with only a, a is reduced; with only b, f*b is formed and reduced; with
// both, a and then f*b are reduced and added mod p, using the one-bit-per-cycle
// remainder unit; one word at a time, the next input taken once the result
// is in the output register. reset: modulus 2, scale 1, counters cleared
module sparse_vector_axpy_mod_p #(
  parameter int VALUE_BITS = svam_pkg::VALUE_BITS_DEF,
  parameter int INDEX_BITS = svam_pkg::INDEX_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [svam_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [VALUE_BITS-1:0]             cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              start_req,
  input  logic                              a_present,
  input  logic [INDEX_BITS-1:0]             a_index,
  input  logic [VALUE_BITS-1:0]             a_value,
  input  logic                              b_present,
  input  logic [INDEX_BITS-1:0]             b_index,
  input  logic [VALUE_BITS-1:0]             b_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              entry_valid,
  output logic [INDEX_BITS-1:0]             out_index,
  output logic [VALUE_BITS-1:0]             out_value,
  output logic                              take_a,
  output logic                              take_b,
  output logic                              done_res,
  output logic [INDEX_BITS+1:0]             entry_count,
  output logic [INDEX_BITS:0]               result_length
);
  import svam_pkg::*;

  svam_cmd_t  cmd;
  svam_stat_t stat;

  svam_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  svam_dp #(
    .VALUE_BITS (VALUE_BITS),
    .INDEX_BITS (INDEX_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .start_req     (start_req),
    .a_present     (a_present),
    .a_index       (a_index),
    .a_value       (a_value),
    .b_present     (b_present),
    .b_index       (b_index),
    .b_value       (b_value),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .entry_valid   (entry_valid),
    .out_index     (out_index),
    .out_value     (out_value),
    .take_a        (take_a),
    .take_b        (take_b),
    .done_res      (done_res),
    .entry_count   (entry_count),
    .result_length (result_length),
    .cmd           (cmd),
    .stat          (stat)
  );

  // an emitted entry always carries a nonzero value
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (entry_valid == (out_value != '0)))
    else $error("entry_valid does not match out_value");

  // no head means nothing consumed and nothing emitted
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && done_res) |-> (!take_a && !take_b && !entry_valid))
    else $error("done word consumed or emitted");

  // a suppressed entry reports index zero
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !entry_valid) |-> (out_index == '0))
    else $error("nonzero index on suppressed entry");

  // one word at a time: input closes right after an accept
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while busy");

endmodule

/* sv/svam_ctrl.sv */
// sequencing state machine for one merge step
// depends on svam_pkg; drives svam_dp through command and status structs
module svam_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  svam_pkg::svam_stat_t  stat,
  output svam_pkg::svam_cmd_t   cmd
);
  import svam_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_RED_A  = 3'd2;
  localparam logic [2:0] S_MUL    = 3'd3;
  localparam logic [2:0] S_RED_P  = 3'd4;
  localparam logic [2:0] S_ADD    = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.none_present) begin
          state_next = S_ADD;
        end else if (stat.take_a) begin
          cmd.load_a = 1'b1;
          state_next = S_RED_A;
        end else begin
          state_next = S_MUL;
        end
      end
      S_RED_A: begin
        cmd.step = 1'b1;
        if (stat.rem_last) begin
          cmd.save_a = 1'b1;
          state_next = stat.take_b ? S_MUL : S_ADD;
        end
      end
      S_MUL: begin
        cmd.load_prod = 1'b1;
        state_next    = S_RED_P;
      end
      S_RED_P: begin
        cmd.step = 1'b1;
        if (stat.rem_last) begin
          state_next = S_ADD;
        end
      end
      S_ADD: begin
        cmd.calc_val = 1'b1;
        state_next   = S_FINISH;
      end
      S_FINISH: begin
        // hold until the output register can take the word
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* sv/svam_dp.sv */
// datapath: input latch, head compare, shared bit-serial remainder unit,
// multiplier, modular add, counters and output register; depends on svam_pkg
module svam_dp #(
  parameter int VALUE_BITS = svam_pkg::VALUE_BITS_DEF,
  parameter int INDEX_BITS = svam_pkg::INDEX_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [svam_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [VALUE_BITS-1:0]             cfg_data,
  input  logic                              start_req,
  input  logic                              a_present,
  input  logic [INDEX_BITS-1:0]             a_index,
  input  logic [VALUE_BITS-1:0]             a_value,
  input  logic                              b_present,
  input  logic [INDEX_BITS-1:0]             b_index,
  input  logic [VALUE_BITS-1:0]             b_value,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic                              entry_valid,
  output logic [INDEX_BITS-1:0]             out_index,
  output logic [VALUE_BITS-1:0]             out_value,
  output logic                              take_a,
  output logic                              take_b,
  output logic                              done_res,
  output logic [INDEX_BITS+1:0]             entry_count,
  output logic [INDEX_BITS:0]               result_length,
  input  svam_pkg::svam_cmd_t               cmd,
  output svam_pkg::svam_stat_t              stat
);
  import svam_pkg::*;

  localparam int PW    = VALUE_BITS + 1;
  localparam int DW    = 2 * VALUE_BITS;
  localparam int CW    = $clog2(DW + 1);
  localparam int CNT_W = INDEX_BITS + 2;
  localparam int LEN_W = INDEX_BITS + 1;

  logic [VALUE_BITS-1:0] modulus;
  logic [VALUE_BITS-1:0] scale;

  logic                  start_l;
  logic                  ap_l;
  logic                  bp_l;
  logic [INDEX_BITS-1:0] ai_l;
  logic [INDEX_BITS-1:0] bi_l;
  logic [VALUE_BITS-1:0] av_l;
  logic [VALUE_BITS-1:0] bv_l;

  logic [DW-1:0]         dd;
  logic [VALUE_BITS-1:0] rem;
  logic [CW-1:0]         cnt;
  logic [VALUE_BITS-1:0] ra;
  logic [VALUE_BITS-1:0] val;
  logic [CNT_W-1:0]      weight_count;
  logic [LEN_W-1:0]      length_reg;

  logic [PW-1:0]         p_eff;
  logic                  ta;
  logic                  tb;
  logic [PW-1:0]         trial;
  logic [VALUE_BITS-1:0] rem_next;
  logic [DW-1:0]         prod;
  logic [PW-1:0]         sum;
  logic [PW-1:0]         sum_red;
  logic                  nz;
  logic [INDEX_BITS-1:0] idx_sel;
  logic [CNT_W-1:0]      wc_base;
  logic [CNT_W-1:0]      weight_count_next;
  logic [LEN_W-1:0]      length_next;

  // modulus below two acts as two
  assign p_eff = ({1'b0, modulus} < PW'(2)) ? PW'(2) : {1'b0, modulus};

  assign ta = ap_l && (!bp_l || (ai_l <= bi_l));
  assign tb = bp_l && (!ap_l || (bi_l <= ai_l));

  // restoring remainder, one dividend bit per cycle
  assign trial    = {rem, dd[DW-1]};
  assign rem_next = (trial >= p_eff) ? VALUE_BITS'(trial - p_eff) : trial[VALUE_BITS-1:0];

  assign prod = DW'(scale) * DW'(bv_l);

  assign sum     = PW'(ra) + PW'(rem);
  assign sum_red = (sum >= p_eff) ? (sum - p_eff) : sum;

  assign nz      = (val != '0);
  assign idx_sel = ta ? ai_l : bi_l;
  assign wc_base = start_l ? '0 : weight_count;
  assign weight_count_next = (nz && (wc_base != '1)) ? (wc_base + CNT_W'(1)) : wc_base;
  assign length_next = nz ? (LEN_W'(idx_sel) + LEN_W'(1))
                          : (start_l ? '0 : length_reg);

  assign stat.none_present = !ap_l && !bp_l;
  assign stat.take_a       = ta;
  assign stat.take_b       = tb;
  assign stat.rem_last     = (cnt == CW'(1));
  assign stat.out_free     = !out_valid || out_ready;

  assign entry_count   = weight_count;
  assign result_length = length_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= VALUE_BITS'(2);
      scale   <= VALUE_BITS'(1);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_MODULUS: modulus <= cfg_data;
        REG_SCALE:   scale   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      start_l <= start_req;
      ap_l    <= a_present;
      ai_l    <= a_index;
      av_l    <= a_value;
      bp_l    <= b_present;
      bi_l    <= b_index;
      bv_l    <= b_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_a) begin
      dd  <= {av_l, {VALUE_BITS{1'b0}}};
      rem <= '0;
      cnt <= CW'(VALUE_BITS);
    end else if (cmd.load_prod) begin
      dd  <= prod;
      rem <= '0;
      cnt <= CW'(DW);
    end else if (cmd.step) begin
      dd  <= {dd[DW-2:0], 1'b0};
      rem <= rem_next;
      cnt <= cnt - CW'(1);
    end
    if (cmd.step && cmd.save_a) begin
      ra <= rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc_val) begin
      if (ta && tb) begin
        val <= VALUE_BITS'(sum_red);
      end else if (ta) begin
        val <= ra;
      end else if (tb) begin
        val <= rem;
      end else begin
        val <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      weight_count <= '0;
      length_reg   <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.finish) begin
        weight_count <= weight_count_next;
        length_reg   <= length_next;
        out_valid    <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      entry_valid <= nz;
      out_index   <= nz ? idx_sel : '0;
      out_value   <= val;
      take_a      <= ta;
      take_b      <= tb;
      done_res    <= !ap_l && !bp_l;
    end
  end

endmodule

/* tb/sv/tb_sparse_vector_axpy_mod_p.sv */
// testbench for sparse_vector_axpy_mod_p: merges of sorted sparse vectors over GF(p)
// checked word by word against an in-bench prediction, with random idling on both sides
// depends on svam_pkg and the sparse_vector_axpy_mod_p rtl
module tb_sparse_vector_axpy_mod_p;
  timeunit 1ns;
  timeprecision 1ps;
  import svam_pkg::*;

  localparam int VB = VALUE_BITS_DEF;
  localparam int IB = INDEX_BITS_DEF;
  localparam logic [IB-1:0] IDX_MAX = '1;
  localparam logic [VB-1:0] VAL_MAX = '1;

  typedef struct packed {
    logic          start;
    logic          a_pres;
    logic [IB-1:0] a_idx;
    logic [VB-1:0] a_val;
    logic          b_pres;
    logic [IB-1:0] b_idx;
    logic [VB-1:0] b_val;
  } merge_word_t;

  typedef struct packed {
    logic          emit;
    logic [IB-1:0] idx;
    logic [VB-1:0] val;
    logic          took_a;
    logic          took_b;
    logic          done;
    logic [IB+1:0] count;
    logic [IB:0]   length;
  } merge_result_t;

  typedef struct packed {
    logic [IB-1:0] idx;
    logic [VB-1:0] val;
  } entry_t;

  logic                    clk;
  logic                    rst = 1'b1;
  logic                    cfg_wr_en = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = REG_MODULUS;
  logic [VB-1:0]           cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    start_req = 1'b0;
  logic                    a_present = 1'b0;
  logic [IB-1:0]           a_index = '0;
  logic [VB-1:0]           a_value = '0;
  logic                    b_present = 1'b0;
  logic [IB-1:0]           b_index = '0;
  logic [VB-1:0]           b_value = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic                    entry_valid;
  logic [IB-1:0]           out_index;
  logic [VB-1:0]           out_value;
  logic                    take_a;
  logic                    take_b;
  logic                    done_res;
  logic [IB+1:0]           entry_count;
  logic [IB:0]             result_length;

  sparse_vector_axpy_mod_p uut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .start_req(start_req),
    .a_present(a_present), .a_index(a_index), .a_value(a_value),
    .b_present(b_present), .b_index(b_index), .b_value(b_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .entry_valid(entry_valid), .out_index(out_index), .out_value(out_value),
    .take_a(take_a), .take_b(take_b), .done_res(done_res),
    .entry_count(entry_count), .result_length(result_length)
  );

  // predictor copy of the block registers
  logic [VB-1:0]   field_mod = 16'd2;
  logic [VB-1:0]   field_scale = 16'd1;
  logic [IB+1:0]   weight_q = '0;
  logic [IB:0]     length_q = '0;

  merge_result_t   pending_entries[$];
  int              mismatches = 0;
  int              sent_words = 0;
  int              send_idle_pct = 0;
  int              recv_idle_pct = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #6_000_000;
    $display("tb_sparse_vector_axpy_mod_p: errors");
    $finish;
  end

  function automatic merge_result_t predict_merge_step(merge_word_t w);
    longint unsigned p, av, fbv, v;
    merge_result_t r;
    p = (field_mod < 2) ? 2 : field_mod;
    r = '0;
    if (w.start) begin
      weight_q = '0;
      length_q = '0;
    end
    if (!w.a_pres && !w.b_pres) begin
      r.done = 1'b1;
    end else begin
      if (w.a_pres && w.b_pres) begin
        r.took_a = (w.a_idx <= w.b_idx);
        r.took_b = (w.b_idx <= w.a_idx);
      end else begin
        r.took_a = w.a_pres;
        r.took_b = w.b_pres;
      end
      // operands are reduced before use, so unreduced inputs stay in the field
      av = w.a_val % p;
      fbv = ((field_scale % p) * (w.b_val % p)) % p;
      if (r.took_a && r.took_b) v = (av + fbv) % p;
      else if (r.took_a) v = av;
      else v = fbv;
      if (v != 0) begin
        r.emit = 1'b1;
        r.idx = r.took_a ? w.a_idx : w.b_idx;
        r.val = v[VB-1:0];
        if (weight_q != '1) weight_q = weight_q + 1'b1;
        length_q = {1'b0, r.idx} + 1'b1;
      end
    end
    r.count = weight_q;
    r.length = length_q;
    return r;
  endfunction

  function automatic string fmt_result(merge_result_t r);
    return $sformatf("emit=%0d idx=%05h val=%04h ta=%0d tb=%0d done=%0d cnt=%0d len=%0d",
                     r.emit, r.idx, r.val, r.took_a, r.took_b, r.done, r.count, r.length);
  endfunction

  function automatic merge_word_t make_word(logic st, logic ap, logic [IB-1:0] ai,
                                            logic [VB-1:0] av, logic bp,
                                            logic [IB-1:0] bi, logic [VB-1:0] bv);
    return '{start: st, a_pres: ap, a_idx: ai, a_val: av, b_pres: bp, b_idx: bi, b_val: bv};
  endfunction

  function automatic merge_word_t random_word();
    merge_word_t w;
    w.start = ($urandom_range(0, 7) == 0);
    w.a_pres = 1'($urandom_range(0, 1));
    w.a_idx = IB'($urandom);
    w.a_val = VB'($urandom);
    w.b_pres = 1'($urandom_range(0, 1));
    w.b_idx = IB'($urandom);
    w.b_val = VB'($urandom);
    return w;
  endfunction

  // random result-side backpressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : check_out
    merge_result_t seen, want;
    if (!rst && out_valid && out_ready) begin
      seen = {entry_valid, out_index, out_value, take_a, take_b, done_res,
              entry_count, result_length};
      if (pending_entries.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: %s", fmt_result(seen));
      end else begin
        want = pending_entries.pop_front();
        if (seen !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected %s", fmt_result(want));
            $display("          actual   %s", fmt_result(seen));
          end
        end
      end
    end
  end

  task automatic send_word(input merge_word_t w, output merge_result_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    start_req <= w.start;
    a_present <= w.a_pres;
    a_index <= w.a_idx;
    a_value <= w.a_val;
    b_present <= w.b_pres;
    b_index <= w.b_idx;
    b_value <= w.b_val;
    do @(posedge clk); while (!in_ready);
    r = predict_merge_step(w);
    pending_entries.push_back(r);
    sent_words++;
  endtask

  // wait until every word is back and the block sits idle
  task automatic settle_block();
    in_valid <= 1'b0;
    while (pending_entries.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_field_config(input logic [VB-1:0] modulus_val,
                                  input logic [VB-1:0] scale_val);
    settle_block();
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_MODULUS;
    cfg_data <= modulus_val;
    @(posedge clk);
    field_mod = modulus_val;
    cfg_index <= REG_SCALE;
    cfg_data <= scale_val;
    @(posedge clk);
    field_scale = scale_val;
    cfg_wr_en <= 1'b0;
  endtask

  // reset field is GF(2) with scale 1: merge-add is xor of low bits
  task automatic test_default_field();
    merge_result_t r;
    send_word(make_word(1, 0, IDX_MAX, VAL_MAX, 0, IDX_MAX, VAL_MAX), r);
    send_word(make_word(0, 1, 0, 1, 0, 3, 1), r);
    send_word(make_word(0, 0, 0, 0, 1, 5, 3), r);
    send_word(make_word(0, 1, 7, 1, 1, 7, 1), r);
    send_word(make_word(0, 1, 8, 2, 1, 9, 1), r);
    send_word(make_word(0, 1, 12, 1, 1, 10, 1), r);
  endtask

  task automatic test_wide_field();
    merge_result_t r;
    set_field_config(16'd65521, VAL_MAX);
    send_word(make_word(1, 1, IDX_MAX, VAL_MAX, 0, 0, VAL_MAX), r);
    send_word(make_word(0, 1, 0, 0, 1, 0, 0), r);
    send_word(make_word(0, 0, 0, 0, 1, IDX_MAX, VAL_MAX), r);
    send_word(make_word(0, 1, 20'h80000, 16'd65520, 1, 20'h80000, 1), r);
    // index going backwards: length follows the latest entry
    send_word(make_word(0, 1, 3, 5, 0, 0, 0), r);
    send_word(make_word(0, 1, 20'haaaaa, 16'h5555, 1, 20'h55555, 16'haaaa), r);
    set_field_config(VAL_MAX, VAL_MAX);
    send_word(make_word(1, 1, 100, VAL_MAX, 1, 100, VAL_MAX), r);
    send_word(make_word(0, 1, 101, 16'hfffe, 1, 200, 1), r);
  endtask

  task automatic test_modulus_below_two();
    merge_result_t r;
    set_field_config(16'd0, 16'd3);
    send_word(make_word(1, 1, 4, 3, 0, 0, 0), r);
    send_word(make_word(0, 1, 6, 1, 1, 6, 1), r);
    set_field_config(16'd1, 16'd1);
    send_word(make_word(0, 0, 0, 0, 1, 9, 5), r);
    send_word(make_word(1, 0, 1, 1, 0, 2, 2), r);
  endtask

  task automatic test_zero_scale();
    merge_result_t r;
    set_field_config(16'd13, 16'd0);
    send_word(make_word(1, 0, 0, 0, 1, 2, 5), r);
    send_word(make_word(0, 1, 4, 4, 1, 4, 9), r);
    send_word(make_word(0, 1, 5, 13, 0, 0, 0), r);
    send_word(make_word(0, 1, 30, 7, 1, 20, 7), r);
  endtask

  task automatic build_vector(input longint unsigned base, input int p, output entry_t v[$]);
    int len, k;
    longint unsigned cur;
    entry_t e;
    v = {};
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 24) : $urandom_range(0, 8);
    cur = base + $urandom_range(0, 3);
    for (k = 0; k < len && cur <= IDX_MAX; k++) begin
      e.idx = cur[IB-1:0];
      // mostly proper field values, now and then zero or unreduced
      e.val = ($urandom_range(0, 15) == 0) ? VB'($urandom_range(0, 65535))
                                           : VB'($urandom_range(1, p - 1));
      v.push_back(e);
      cur += ($urandom_range(0, 9) == 0) ? $urandom_range(4, 5000) : $urandom_range(1, 3);
    end
  endtask

  // one full merge of two sorted vectors, heads advanced by the predicted takes
  task automatic run_merge();
    entry_t va[$], vb[$];
    merge_word_t w;
    merge_result_t r;
    longint unsigned base;
    int p;
    logic first;
    p = (field_mod < 2) ? 2 : field_mod;
    case ($urandom_range(0, 3))
      0: base = 0;
      1: base = $urandom_range(0, 2**IB - 1);
      2: base = 2**IB - 48;
      default: base = $urandom_range(0, 1000);
    endcase
    build_vector(base, p, va);
    build_vector(base, p, vb);
    first = 1'b1;
    while (va.size() != 0 || vb.size() != 0) begin
      w = random_word();
      w.start = first ? ($urandom_range(0, 7) != 0) : 1'b0;
      w.a_pres = (va.size() != 0);
      if (w.a_pres) begin
        w.a_idx = va[0].idx;
        w.a_val = va[0].val;
      end
      w.b_pres = (vb.size() != 0);
      if (w.b_pres) begin
        w.b_idx = vb[0].idx;
        w.b_val = vb[0].val;
      end
      send_word(w, r);
      if (r.took_a) void'(va.pop_front());
      if (r.took_b) void'(vb.pop_front());
      first = 1'b0;
    end
    w = random_word();
    w.start = 1'b0;
    w.a_pres = 1'b0;
    w.b_pres = 1'b0;
    send_word(w, r);
  endtask

  task automatic random_merges(input int n);
    int target, since_cfg, prior, mp;
    logic [VB-1:0] m, s;
    merge_result_t r;
    target = sent_words + n;
    since_cfg = 1000;
    while (sent_words < target) begin
      if (since_cfg >= 100) begin
        case ($urandom_range(0, 6))
          0: m = 16'd2;
          1: m = 16'd3;
          2: m = 16'd7;
          3: m = 16'd251;
          4: m = 16'd65521;
          5: m = VAL_MAX;
          default: m = VB'($urandom_range(2, 65535));
        endcase
        mp = m;
        case ($urandom_range(0, 5))
          0: s = 16'd0;
          1: s = 16'd1;
          2: s = VB'(mp - 1);
          3: s = VAL_MAX;
          default: s = VB'($urandom_range(0, mp - 1));
        endcase
        set_field_config(m, s);
        since_cfg = 0;
      end
      prior = sent_words;
      if ($urandom_range(0, 7) == 0) begin
        // noise: arbitrary heads, unsorted, unreduced
        repeat ($urandom_range(3, 6)) send_word(random_word(), r);
      end else begin
        run_merge();
      end
      since_cfg += sent_words - prior;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 11;
    recv_idle_pct = 53;
    test_default_field();
    test_wide_field();
    test_modulus_below_two();
    test_zero_scale();
    random_merges(500);
    send_idle_pct = 53;
    recv_idle_pct = 11;
    random_merges(500);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_merges(500);
    settle_block();
    repeat (60) @(posedge clk);
    if (mismatches == 0 && pending_entries.size() == 0) begin
      $display("tb_sparse_vector_axpy_mod_p: clean");
    end else begin
      $display("tb_sparse_vector_axpy_mod_p: errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/svam_pkg.sv
sv/svam_ctrl.sv
sv/svam_dp.sv
sv/sparse_vector_axpy_mod_p.sv
tb/sv/tb_sparse_vector_axpy_mod_p.sv
